// ===== hw/rtl/eflsel_pkg.sv =====
// ----------------------------------------------------------------------------
// eflsel_pkg: shared types and constants of the earliest-finish lane selector
// Holds the command, status and sequencer codes, the field widths and the
// structs that travel between the top level and the lane cells.
// ----------------------------------------------------------------------------
package eflsel_pkg;

  localparam int LANE_COUNT  = 8;
  localparam int MAX_BATCH   = 16;
  localparam int QUEUE_DEPTH = 8;

  localparam int LANE_W = 3;   // lane_index / chosen_lane field
  localparam int BATCH_W = 5;  // batch length field
  localparam int TIME_W = 40;
  localparam int EST_W = 32;
  localparam int WGT_W = 16;
  localparam int EIDX_W = $clog2(MAX_BATCH + 1);
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WGT_W-1:0] Q15_ONE = 16'd32768;
  localparam logic [WGT_W-1:0] Q15_HALF = 16'd16384;
  localparam logic [WGT_W-1:0] JIT_KEEP = 16'd26214;  // 0.8
  localparam logic [WGT_W-1:0] JIT_NEW = 16'd6554;    // 0.2
  localparam logic [EST_W-1:0] MIN_SAMPLE = 32'd16;
  localparam logic [EST_W-1:0] RST_EST = 32'd16000;
  localparam logic [WGT_W-1:0] RST_ALPHA = 16'd3277;

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_SUBMIT = 2'd1,
    CMD_DONE   = 2'd2,
    CMD_INIT   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ALPHA  = 2'd0,
    REG_JIT_W  = 2'd1,
    REG_ERR_W  = 2'd2,
    REG_INIT_T = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_CHAIN,
    S_OUT
  } seq_e;

  // operation broadcast to every cell
  typedef struct packed {
    logic               run;
    logic [1:0]         phase;
    cmd_e               cmd;
    logic [TIME_W-1:0]  now;
    logic [LANE_W-1:0]  lane;
    logic [EIDX_W-1:0]  batch;
    logic [EST_W-1:0]   base_est;
    logic [WGT_W-1:0]   alpha;
    logic [WGT_W-1:0]   jit_w;
    logic [WGT_W-1:0]   err_w;
  } op_t;

  // running best handed along the cell chain
  typedef struct packed {
    logic               valid;
    logic               first;
    logic [LANE_W-1:0]  lane;
    logic [TIME_W-1:0]  val;
  } chain_t;

  // per-cell status seen by the top level
  typedef struct packed {
    logic [TIME_W-1:0]  pred;
    logic [TIME_W-1:0]  fin;
    logic               full;
    logic               empty;
  } cell_stat_t;

endpackage

// ===== hw/rtl/eflsel_cell.sv =====
// ----------------------------------------------------------------------------
// eflsel_cell: one lane of the selector
// Holds the lane's estimates, jitter and error state and its job queue,
// forms the lane prediction and takes part in the earliest-finish chain.
// ----------------------------------------------------------------------------
module eflsel_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [eflsel_pkg::LANE_W-1:0] lane_id_i,
  input  eflsel_pkg::op_t             op_i,
  input  eflsel_pkg::chain_t          chain_i,
  output eflsel_pkg::chain_t          chain_o,
  output eflsel_pkg::cell_stat_t      stat_o
);
  import eflsel_pkg::*;

  // lane state
  logic [TIME_W-1:0] last_done_q, jit_q, aerr_q, tail_fin_q;
  logic [QW-1:0]     head_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MAX_BATCH:0] est_vld_q;
  logic [EST_W-1:0]  est_mem_q [MAX_BATCH+1];
  logic [BATCH_W-1:0] q_batch_q [QUEUE_DEPTH];
  logic [TIME_W-1:0] q_sub_q [QUEUE_DEPTH];
  logic [TIME_W-1:0] q_fin_q [QUEUE_DEPTH];

  // working registers
  logic [TIME_W-1:0] start_q, pred_q, sub_q, fin_q, aerr_new_q;
  logic [EST_W-1:0]  est_q, est_pb_q, sample_q;
  logic [EIDX_W-1:0] pb_q;
  logic [WGT_W+TIME_W-1:0] mj_q, me_q;
  logic [WGT_W+EST_W-1:0]  pa_q, pn_q;
  logic [WGT_W+TIME_W-1:0] pj_q, pe_q;
  logic              full_q, empty_q;
  chain_t            chain_q;

  logic ph0, ph1, ph2, ph3, sel, do_push, do_pop;
  logic [TIME_W-1:0] ready, start_d, started, diff, aerr_d;
  logic [EST_W-1:0]  est_rd, est_pb_rd, sample_d, est_new;
  logic [WGT_W-1:0]  alpha_c, alpha_n;
  logic [WGT_W+TIME_W:0] mj_r, me_r;
  logic [TIME_W+3:0] sum;
  logic [TIME_W-1:0] pred_d, jit_new;
  logic [WGT_W+EST_W:0] est_acc;
  logic [WGT_W+TIME_W:0] jit_acc;
  logic [CNT_W:0]    tail_sum;
  logic [QW-1:0]     tail_idx, head_nx;

  assign ph0 = op_i.run && (op_i.phase == 2'd0);
  assign ph1 = op_i.run && (op_i.phase == 2'd1);
  assign ph2 = op_i.run && (op_i.phase == 2'd2);
  assign ph3 = op_i.run && (op_i.phase == 2'd3);
  assign sel = (op_i.lane == lane_id_i);
  assign do_push = ph2 && sel && (op_i.cmd == CMD_SUBMIT) && !full_q;
  assign do_pop  = ph3 && sel && (op_i.cmd == CMD_DONE) && !empty_q;

  // prediction path
  always_comb begin
    ready   = (cnt_q != '0) ? tail_fin_q : last_done_q;
    start_d = (op_i.now > ready) ? op_i.now : ready;
    est_rd  = est_vld_q[op_i.batch] ? est_mem_q[op_i.batch] : op_i.base_est;
    mj_r    = {1'b0, mj_q} + (WGT_W+TIME_W+1)'(Q15_HALF);
    me_r    = {1'b0, me_q} + (WGT_W+TIME_W+1)'(Q15_HALF);
    sum     = (TIME_W+4)'(start_q) + (TIME_W+4)'(est_q)
            + (TIME_W+4)'(mj_r[WGT_W+TIME_W:15]) + (TIME_W+4)'(me_r[WGT_W+TIME_W:15]);
    pred_d  = (sum[TIME_W+3:TIME_W] != '0) ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  end

  // completion path
  always_comb begin
    est_pb_rd = est_vld_q[pb_q] ? est_mem_q[pb_q] : op_i.base_est;
    started   = (sub_q > last_done_q) ? sub_q : last_done_q;
    diff      = (op_i.now > started) ? (op_i.now - started) : '0;
    if (diff[TIME_W-1:EST_W] != '0) begin
      sample_d = {EST_W{1'b1}};
    end else if (diff[EST_W-1:0] < MIN_SAMPLE) begin
      sample_d = MIN_SAMPLE;
    end else begin
      sample_d = diff[EST_W-1:0];
    end
    aerr_d  = (op_i.now >= fin_q) ? (op_i.now - fin_q) : (fin_q - op_i.now);
    alpha_c = (op_i.alpha > Q15_ONE) ? Q15_ONE : op_i.alpha;
    alpha_n = Q15_ONE - alpha_c;
    est_acc = {1'b0, pa_q} + {1'b0, pn_q} + (WGT_W+EST_W+1)'(Q15_HALF);
    est_new = est_acc[EST_W+14:15];
    jit_acc = {1'b0, pj_q} + {1'b0, pe_q} + (WGT_W+TIME_W+1)'(Q15_HALF);
    jit_new = (jit_q == '0) ? aerr_new_q : jit_acc[TIME_W+14:15];
  end

  // queue indices
  always_comb begin
    tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q);
    tail_idx = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
             ? QW'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    head_nx  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  end

  // lane state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_done_q <= '0;
      jit_q       <= '0;
      aerr_q      <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      est_vld_q   <= '0;
      chain_q     <= '0;
    end else begin
      if (ph0 && (op_i.cmd == CMD_INIT)) begin
        last_done_q <= op_i.now;
        jit_q       <= '0;
        aerr_q      <= '0;
        head_q      <= '0;
        cnt_q       <= '0;
        est_vld_q   <= '0;
      end
      if (do_push) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (do_pop) begin
        est_vld_q[pb_q] <= 1'b1;
        jit_q       <= jit_new;
        aerr_q      <= aerr_new_q;
        last_done_q <= op_i.now;
        head_q      <= head_nx;
        cnt_q       <= cnt_q - 1'b1;
      end
      // chain stage: keep own prediction on strict improvement only
      chain_q.valid <= chain_i.valid;
      chain_q.first <= 1'b0;
      if (chain_i.first || (pred_q < chain_i.val)) begin
        chain_q.lane <= lane_id_i;
        chain_q.val  <= pred_q;
      end else begin
        chain_q.lane <= chain_i.lane;
        chain_q.val  <= chain_i.val;
      end
    end
  end

  // payload and storage
  always_ff @(posedge clk_i) begin
    if (ph0) begin
      start_q <= start_d;
      est_q   <= est_rd;
      mj_q    <= op_i.jit_w * jit_q;
      me_q    <= op_i.err_w * aerr_q;
      pb_q    <= EIDX_W'(q_batch_q[head_q]);
      sub_q   <= q_sub_q[head_q];
      fin_q   <= q_fin_q[head_q];
      full_q  <= (cnt_q == CNT_W'(QUEUE_DEPTH));
      empty_q <= (cnt_q == '0);
    end
    if (ph1) begin
      pred_q     <= pred_d;
      est_pb_q   <= est_pb_rd;
      sample_q   <= sample_d;
      aerr_new_q <= aerr_d;
    end
    if (ph2) begin
      pa_q <= alpha_c * sample_q;
      pn_q <= alpha_n * est_pb_q;
      pj_q <= JIT_KEEP * jit_q;
      pe_q <= JIT_NEW * aerr_new_q;
    end
    if (do_push) begin
      q_batch_q[tail_idx] <= BATCH_W'(op_i.batch);
      q_sub_q[tail_idx]   <= op_i.now;
      q_fin_q[tail_idx]   <= pred_q;
      tail_fin_q          <= pred_q;
    end
    if (do_pop) begin
      est_mem_q[pb_q] <= est_new;
    end
  end

  assign chain_o      = chain_q;
  assign stat_o.pred  = pred_q;
  assign stat_o.fin   = fin_q;
  assign stat_o.full  = full_q;
  assign stat_o.empty = empty_q;

endmodule

// ===== hw/rtl/earliest_finish_lane_selector.sv =====
// ----------------------------------------------------------------------------
// earliest_finish_lane_selector: earliest-finish lane scheduler, EWMA based
// Sequence: an accepted item runs phases 0..3 in every lane cell, is staged
//   and then loaded into the output register; select also waits for the chain walk.
// Throughput: one item at a time; the next item is taken in the cycle after the
//   result is loaded, and the load waits while the previous result is held by the
//   receiver.
// Reset: estimates read as 16000, lanes empty, weights at their reset values.
// ----------------------------------------------------------------------------
module earliest_finish_lane_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [eflsel_pkg::TIME_W-1:0]    now_time_i,
  input  logic [eflsel_pkg::LANE_W-1:0]    lane_index_i,
  input  logic [eflsel_pkg::BATCH_W-1:0]   batch_len_i,
  // result out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [eflsel_pkg::LANE_W-1:0]    chosen_lane_o,
  output logic [eflsel_pkg::TIME_W-1:0]    predicted_finish_o,
  output logic [1:0]                       status_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);
  import eflsel_pkg::*;

  // configuration registers
  logic [WGT_W-1:0] alpha_q, jit_w_q, err_w_q;
  logic [EST_W-1:0] init_t_q, base_est_q;

  // sequencer
  seq_e              state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  cmd_e              cmd_q;
  logic [TIME_W-1:0] now_q;
  logic [LANE_W-1:0] lane_q;
  logic [EIDX_W-1:0] batch_q;
  logic              in_acc, out_load;

  // result staging and output register
  logic [LANE_W-1:0] res_lane_q, res_lane_d;
  logic [TIME_W-1:0] res_fin_q, res_fin_d;
  status_e           res_st_q, res_st_d;
  logic              res_cap;
  logic              out_valid_q;
  logic [LANE_W-1:0] out_lane_q;
  logic [TIME_W-1:0] out_fin_q;
  status_e           out_st_q;

  op_t        op;
  chain_t     chain [LANE_COUNT+1];
  cell_stat_t stat [LANE_COUNT];
  cell_stat_t cur;

  logic [BATCH_W-1:0] b_sat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  // batch size clamped into 1..MAX_BATCH
  always_comb begin
    if (batch_len_i == '0) begin
      b_sat = BATCH_W'(1);
    end else if (batch_len_i > BATCH_W'(MAX_BATCH)) begin
      b_sat = BATCH_W'(MAX_BATCH);
    end else begin
      b_sat = batch_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= RST_ALPHA;
      jit_w_q    <= '0;
      err_w_q    <= '0;
      init_t_q   <= RST_EST;
      base_est_q <= RST_EST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_ALPHA:  alpha_q  <= cfg_data_i[WGT_W-1:0];
          REG_JIT_W:  jit_w_q  <= cfg_data_i[WGT_W-1:0];
          REG_ERR_W:  err_w_q  <= cfg_data_i[WGT_W-1:0];
          REG_INIT_T: init_t_q <= cfg_data_i;
          default: ;
        endcase
      end
      // init reloads every estimate: captured once here, cells fall back to it
      if (in_acc && (cmd_e'(command_i) == CMD_INIT)) begin
        base_est_q <= init_t_q;
      end
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q   <= now_time_i;
      lane_q  <= LANE_W'(lane_index_i % LANE_COUNT);
      batch_q <= EIDX_W'(b_sat);
    end
  end

  // broadcast to the lane cells
  assign op.run      = (state_q == S_RUN);
  assign op.phase    = phase_q;
  assign op.cmd      = cmd_q;
  assign op.now      = now_q;
  assign op.lane     = lane_q;
  assign op.batch    = batch_q;
  assign op.base_est = base_est_q;
  assign op.alpha    = alpha_q;
  assign op.jit_w    = jit_w_q;
  assign op.err_w    = err_w_q;

  // chain head: starts once every cell has its prediction (phase 2)
  assign chain[0].valid = op.run && (phase_q == 2'd2) && (cmd_q == CMD_SELECT);
  assign chain[0].first = 1'b1;
  assign chain[0].lane  = '0;
  assign chain[0].val   = '0;

  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    eflsel_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lane_id_i (LANE_W'(g)),
      .op_i      (op),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1]),
      .stat_o    (stat[g])
    );
  end

  assign cur = stat[lane_q];

  // result of the finished item
  always_comb begin
    res_lane_d = lane_q;
    res_fin_d  = '0;
    res_st_d   = ST_OK;
    case (cmd_q)
      CMD_SELECT: begin
        res_lane_d = chain[LANE_COUNT].lane;
        res_fin_d  = chain[LANE_COUNT].val;
      end
      CMD_SUBMIT: begin
        res_fin_d = cur.pred;
        res_st_d  = cur.full ? ST_FULL : ST_OK;
      end
      CMD_DONE: begin
        res_fin_d = cur.empty ? '0 : cur.fin;
        res_st_d  = cur.empty ? ST_EMPTY : ST_OK;
      end
      CMD_INIT: begin
        res_lane_d = '0;
      end
      default: ;
    endcase
  end

  // sequencer: phases 0..3 run in every cell, select then waits for the chain
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    res_cap  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        phase_d = '0;
        if (in_acc) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        phase_d = phase_q + 1'b1;
        if (phase_q == 2'd3) begin
          if ((cmd_q != CMD_SELECT) || chain[LANE_COUNT].valid) begin
            res_cap = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_CHAIN;
          end
        end
      end
      S_CHAIN: begin
        if (chain[LANE_COUNT].valid) begin
          res_cap = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      cmd_q       <= CMD_SELECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (in_acc) begin
        cmd_q <= cmd_e'(command_i);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_cap) begin
      res_lane_q <= res_lane_d;
      res_fin_q  <= res_fin_d;
      res_st_q   <= res_st_d;
    end
    if (out_load) begin
      out_lane_q <= res_lane_q;
      out_fin_q  <= res_fin_q;
      out_st_q   <= res_st_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign chosen_lane_o      = out_lane_q;
  assign predicted_finish_o = out_fin_q;
  assign status_o           = out_st_q;

endmodule

// ===== hw/rtl/eflsel_checker.sv =====
// ----------------------------------------------------------------------------
// eflsel_checker: port-level checks for the lane selector
// Watches the item and result channels of the top level; bound below.
// ----------------------------------------------------------------------------
module eflsel_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [eflsel_pkg::LANE_W-1:0]  chosen_lane_o,
  input logic [eflsel_pkg::TIME_W-1:0]  predicted_finish_o,
  input logic [1:0]                     status_o
);
  import eflsel_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(predicted_finish_o)
      && $stable(chosen_lane_o) && $stable(status_o)))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in flight");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != ST_RSVD))
    else $error("reserved status code");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |-> (predicted_finish_o == '0))
    else $error("empty-queue result carries a finish time");

endmodule

bind earliest_finish_lane_selector eflsel_checker u_eflsel_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .chosen_lane_o      (chosen_lane_o),
  .predicted_finish_o (predicted_finish_o),
  .status_o           (status_o)
);

// ===== bench/eflsel_checker.sv =====
// ----------------------------------------------------------------------------
// eflsel_scoreboard: scoreboard for the earliest-finish lane selector
// Watches the item, result and register channels, keeps its own copy of the
// lane estimators and queues, and compares every result with its prediction.
// ----------------------------------------------------------------------------
module eflsel_scoreboard
  import eflsel_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         command_i,
  input  logic [TIME_W-1:0]  now_time_i,
  input  logic [LANE_W-1:0]  lane_index_i,
  input  logic [BATCH_W-1:0] batch_len_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [LANE_W-1:0]  chosen_lane_i,
  input  logic [TIME_W-1:0]  predicted_finish_i,
  input  logic [1:0]         status_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 waiting_o
);

  localparam logic [63:0] T40_MAX = 64'hFF_FFFF_FFFF;
  localparam int RING_DEPTH = 16;

  typedef struct {
    logic [LANE_W-1:0] lane;
    logic [TIME_W-1:0] fin;
    status_e           st;
  } outcome_t;

  // expected results in order, as a ring
  outcome_t          ring_q [RING_DEPTH];
  int                wr_n, rd_n;

  logic [15:0]       alpha_r, jit_w_r, err_w_r;
  logic [31:0]       init_est_r;
  logic [31:0]       est_r    [LANE_COUNT][MAX_BATCH+1];
  logic [TIME_W-1:0] done_t_r [LANE_COUNT];
  logic [63:0]       jitter_r [LANE_COUNT];
  longint            last_err_r [LANE_COUNT];
  logic [4:0]        job_batch_r [LANE_COUNT][QUEUE_DEPTH];
  logic [TIME_W-1:0] job_sub_r [LANE_COUNT][QUEUE_DEPTH];
  logic [TIME_W-1:0] job_fin_r [LANE_COUNT][QUEUE_DEPTH];
  int                head_r [LANE_COUNT];
  int                count_r [LANE_COUNT];

  assign waiting_o = wr_n - rd_n;

  function automatic logic [63:0] q15(logic [63:0] w, logic [63:0] v);
    return (w * v + 64'd16384) >> 15;
  endfunction

  function automatic logic [63:0] magnitude(longint e);
    return (e < 0) ? 64'(-e) : 64'(e);
  endfunction

  function automatic logic [TIME_W-1:0] finish_on(int l, int b, logic [TIME_W-1:0] now);
    logic [63:0] ready, start, sum;
    ready = 64'(done_t_r[l]);
    if (count_r[l] != 0)
      ready = 64'(job_fin_r[l][(head_r[l] + count_r[l] - 1) % QUEUE_DEPTH]);
    start = (64'(now) > ready) ? 64'(now) : ready;
    sum = start + 64'(est_r[l][b]) + q15(64'(jit_w_r), jitter_r[l])
        + q15(64'(err_w_r), magnitude(last_err_r[l]));
    return (sum > T40_MAX) ? T40_MAX[TIME_W-1:0] : sum[TIME_W-1:0];
  endfunction

  task automatic clear_lanes(logic [TIME_W-1:0] now);
    for (int l = 0; l < LANE_COUNT; l++) begin
      for (int b = 0; b <= MAX_BATCH; b++) est_r[l][b] = init_est_r;
      done_t_r[l] = now;
      jitter_r[l] = '0;
      last_err_r[l] = 0;
      head_r[l] = 0;
      count_r[l] = 0;
    end
  endtask

  // works out one result and moves the lane state on
  task automatic schedule_item(cmd_e cmd, logic [TIME_W-1:0] now, int l, int braw);
    outcome_t    o;
    int          b, slot, pb;
    logic [63:0] p, started, sample, a, nest, ae;
    longint      e;
    b = (braw == 0) ? 1 : ((braw > MAX_BATCH) ? MAX_BATCH : braw);
    o.lane = '0;
    o.fin = '0;
    o.st = ST_OK;
    case (cmd)
      CMD_SELECT: begin
        for (int i = 0; i < LANE_COUNT; i++) begin
          p = 64'(finish_on(i, b, now));
          if (i == 0 || p < 64'(o.fin)) begin
            o.fin = p[TIME_W-1:0];
            o.lane = LANE_W'(i);
          end
        end
      end
      CMD_SUBMIT: begin
        o.lane = LANE_W'(l);
        o.fin = finish_on(l, b, now);
        if (count_r[l] >= QUEUE_DEPTH) begin
          o.st = ST_FULL;
        end else begin
          slot = (head_r[l] + count_r[l]) % QUEUE_DEPTH;
          job_batch_r[l][slot] = 5'(b);
          job_sub_r[l][slot] = now;
          job_fin_r[l][slot] = o.fin;
          count_r[l]++;
        end
      end
      CMD_DONE: begin
        o.lane = LANE_W'(l);
        if (count_r[l] == 0) begin
          o.st = ST_EMPTY;
        end else begin
          slot = head_r[l];
          pb = int'(job_batch_r[l][slot]);
          o.fin = job_fin_r[l][slot];
          head_r[l] = (head_r[l] + 1) % QUEUE_DEPTH;
          count_r[l]--;
          started = (job_sub_r[l][slot] > done_t_r[l]) ? 64'(job_sub_r[l][slot])
                                                       : 64'(done_t_r[l]);
          sample = (64'(now) > started) ? 64'(now) - started : 64'd0;
          if (sample < 16) sample = 64'd16;
          if (sample > 64'hFFFF_FFFF) sample = 64'hFFFF_FFFF;
          a = (alpha_r > 16'd32768) ? 64'd32768 : 64'(alpha_r);
          nest = (a * sample + (64'd32768 - a) * 64'(est_r[l][pb]) + 64'd16384) >> 15;
          est_r[l][pb] = nest[31:0];
          e = longint'({24'd0, now}) - longint'({24'd0, o.fin});
          last_err_r[l] = e;
          ae = magnitude(e);
          if (jitter_r[l] == 0) jitter_r[l] = ae;
          else jitter_r[l] = (64'd26214 * jitter_r[l] + 64'd6554 * ae + 64'd16384) >> 15;
          done_t_r[l] = now;
        end
      end
      default: clear_lanes(now);
    endcase
    ring_q[wr_n % RING_DEPTH] = o;
    wr_n++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t x;
    if (!rst_ni) begin
      alpha_r = RST_ALPHA;
      jit_w_r = '0;
      err_w_r = '0;
      init_est_r = RST_EST;
      clear_lanes('0);
      wr_n = 0;
      rd_n = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (wr_n == rd_n) begin
          $display("%0t: result with nothing expected (lane %0d fin %0d st %0d)",
                   $time, chosen_lane_i, predicted_finish_i, status_i);
          fail_count_o++;
        end else begin
          x = ring_q[rd_n % RING_DEPTH];
          rd_n++;
          if (chosen_lane_i !== x.lane) begin
            $display("%0t: chosen_lane expected %0d actual %0d", $time, x.lane, chosen_lane_i);
            fail_count_o++;
          end
          if (predicted_finish_i !== x.fin) begin
            $display("%0t: predicted_finish expected %0d actual %0d",
                     $time, x.fin, predicted_finish_i);
            fail_count_o++;
          end
          if (status_i !== x.st) begin
            $display("%0t: status expected %0d actual %0d", $time, x.st, status_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_ALPHA:  alpha_r = cfg_data_i[15:0];
          REG_JIT_W:  jit_w_r = cfg_data_i[15:0];
          REG_ERR_W:  err_w_r = cfg_data_i[15:0];
          REG_INIT_T: init_est_r = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        schedule_item(cmd_e'(command_i), now_time_i, int'(lane_index_i), int'(batch_len_i));
    end
  end

endmodule

// ===== bench/earliest_finish_lane_selector_tb.sv =====
// ----------------------------------------------------------------------------
// earliest_finish_lane_selector_tb: stimulus and verdict for the lane selector
// Directed corners first, then random submit/done traffic over several weight
// settings, with random gaps on both sides, a long output hold and a watchdog.
// ----------------------------------------------------------------------------
module earliest_finish_lane_selector_tb;
  import eflsel_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // cycles with no handshake at all
  localparam logic [TIME_W-1:0] T_MAX = '1;

  logic               clk_i, rst_ni;
  logic               in_valid, in_stall;
  logic [1:0]         command;
  logic [TIME_W-1:0]  now_time;
  logic [LANE_W-1:0]  lane_index;
  logic [BATCH_W-1:0] batch_len;
  logic               out_valid, out_stall;
  logic [LANE_W-1:0]  chosen_lane;
  logic [TIME_W-1:0]  predicted_finish;
  logic [1:0]         status;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count, waiting;

  logic               calm;      // no gaps on either side while set
  logic               hold_req;  // asks the receiver for one long hold
  logic [TIME_W-1:0]  clock_t;   // running scheduler time
  int                 idle_cycles;

  earliest_finish_lane_selector dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .now_time_i(now_time),
    .lane_index_i(lane_index), .batch_len_i(batch_len),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chosen_lane_o(chosen_lane), .predicted_finish_o(predicted_finish),
    .status_o(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  eflsel_scoreboard u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .command_i(command), .now_time_i(now_time),
    .lane_index_i(lane_index), .batch_len_i(batch_len),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .chosen_lane_i(chosen_lane), .predicted_finish_i(predicted_finish),
    .status_i(status),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .waiting_o(waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: any handshake resets the count
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each item, one long hold on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !held) begin
        n = 300;
        held = 1'b1;
      end else begin
        n = calm ? 0 : $urandom_range(0, 16);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // offers one item after a random gap and returns on the accepting edge
  task automatic send_item(cmd_e cmd, logic [TIME_W-1:0] now, int lane, int batch);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    now_time   <= now;
    lane_index <= LANE_W'(lane);
    batch_len  <= BATCH_W'(batch);
    do @(posedge clk_i); while (in_stall);
  endtask

  // lets every result drain before a register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed submit/done traffic with a forward-moving clock,
  // plus selects, the odd init and some scrambled times
  task automatic random_items(int count);
    int r, c;
    logic [TIME_W-1:0] t;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 50) calm = 1'b1;
      if (k % 100 == 70) calm = 1'b0;
      clock_t = clock_t + TIME_W'($urandom_range(0, 40000));
      t = clock_t;
      r = $urandom_range(0, 99);
      if (r < 10) t = TIME_W'({$urandom, $urandom}) & T_MAX;
      r = $urandom_range(0, 99);
      if (r < 38) c = CMD_SUBMIT;
      else if (r < 72) c = CMD_DONE;
      else if (r < 97) c = CMD_SELECT;
      else c = CMD_INIT;
      send_item(cmd_e'(c), t, $urandom_range(0, 7),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4));
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    command    = CMD_SELECT;
    now_time   = '0;
    lane_index = '0;
    batch_len  = 5'd1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ALPHA;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    clock_t    = 40'd1000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, done on empty, full queue, batch corners
    send_item(CMD_SELECT, '0, 0, 0);
    send_item(CMD_DONE, 40'd100, 3, 1);
    for (int i = 0; i < 9; i++) send_item(CMD_SUBMIT, 40'd200 + i, 7, (i == 0) ? 0 : 31);
    send_item(CMD_SELECT, 40'd300, 0, 16);
    for (int i = 0; i < 4; i++) send_item(CMD_DONE, 40'd20000 * (i + 1), 7, 1);
    send_item(CMD_SUBMIT, T_MAX, 2, 16);
    send_item(CMD_DONE, T_MAX, 2, 1);
    send_item(CMD_SELECT, T_MAX, 5, 31);
    send_item(CMD_INIT, 40'd5000, 0, 1);
    send_item(CMD_SUBMIT, 40'd5001, 1, 1);
    drain();

    // extreme weights and tiny estimate, then saturation
    write_reg(REG_ALPHA, 32'd32768);
    write_reg(REG_JIT_W, 32'd65535);
    write_reg(REG_ERR_W, 32'd65535);
    write_reg(REG_INIT_T, 32'd16);
    send_item(CMD_INIT, 40'd1000, 0, 1);
    clock_t = 40'd1000;
    random_items(150);
    send_item(CMD_SUBMIT, T_MAX - 40'd5, 4, 3);
    send_item(CMD_DONE, 40'd0, 4, 3);
    send_item(CMD_SELECT, T_MAX, 0, 3);
    drain();

    // alpha above one, huge estimate; long output hold with the input busy
    write_reg(REG_ALPHA, 32'd65535);
    write_reg(REG_JIT_W, 32'd0);
    write_reg(REG_ERR_W, 32'd16384);
    write_reg(REG_INIT_T, 32'hFFFF_FFFF);
    send_item(CMD_INIT, 40'd0, 0, 1);
    clock_t = '0;
    hold_req = 1'b1;
    random_items(150);
    drain();

    // zero alpha, moderate weights
    write_reg(REG_ALPHA, 32'd0);
    write_reg(REG_JIT_W, 32'd20000);
    write_reg(REG_ERR_W, 32'd0);
    write_reg(REG_INIT_T, 32'd16000);
    send_item(CMD_INIT, 40'd0, 0, 1);
    clock_t = '0;
    random_items(150);
    drain();

    write_reg(REG_ALPHA, 32'd3277);
    write_reg(REG_JIT_W, 32'd8192);
    write_reg(REG_ERR_W, 32'd4096);
    random_items(150);
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
